@@ rtl/tail_drop_packet_buffer_unit_assert.svh @@
// Assertion macros shared by the checker files of the packet buffer.
`ifndef TAIL_DROP_PACKET_BUFFER_UNIT_ASSERT_SVH
`define TAIL_DROP_PACKET_BUFFER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define TDPB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdpb assertion failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define TDPB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdpb assertion failed");

`endif

@@ rtl/tdpb_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpb_pkg
// Types and constants shared by the tail-drop packet buffer modules.
// ----------------------------------------------------------------------------
package tdpb_pkg;

	localparam int TIME_W      = 32;
	localparam int PROC_W      = 16;
	localparam int CAP_W       = 5;
	localparam int MAX_DEPTH_DEF = 16;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic [TIME_W-1:0] arrive_ts;
		logic [PROC_W-1:0] service_len;
	} in_item_t;

	typedef struct packed {
		logic              dropped;
		logic [TIME_W-1:0] start_ts;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CHECK
	} eng_state_t;

endpackage

@@ rtl/tdpb_req_queue.sv @@
// ----------------------------------------------------------------------------
// tdpb_req_queue
// Front part: accepts requests and holds up to two of them for the engine.
// ----------------------------------------------------------------------------
module tdpb_req_queue import tdpb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	output logic     req_valid,
	output in_item_t req_data,
	input  logic     req_pop
);

	in_item_t   slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_stall  = (count_q == 2'd2);
	assign req_valid = (count_q != 2'd0);
	assign req_data  = slot_q[rd_ptr_q];
	assign push      = in_valid && !in_stall;
	assign pop       = req_pop && req_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= in_data;
	end

endmodule

@@ rtl/tdpb_engine.sv @@
// ----------------------------------------------------------------------------
// tdpb_engine
// Back part: retires finished packets, decides drop or admit, keeps the
// finish-time memory and drives the result register.
// ----------------------------------------------------------------------------
module tdpb_engine import tdpb_pkg::*; #(
	parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CAP_W-1:0] capacity,
	input  logic             req_valid,
	input  in_item_t         req_data,
	output logic             req_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data
);

	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int OW = $clog2(MAX_DEPTH + 1);
	localparam int CW = (OW > CAP_W) ? OW : CAP_W;
	localparam logic [AW-1:0] LAST_POS = AW'(MAX_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(MAX_DEPTH);

	logic [TIME_W-1:0] fifo_mem [MAX_DEPTH];

	eng_state_t        state_q, state_d;
	logic [AW-1:0]     head_q, tail_q, head_next, tail_next, rd_addr;
	logic [OW-1:0]     occ_q;
	logic [TIME_W-1:0] last_fin_q, arr_q, rd_q;
	logic [PROC_W-1:0] proc_q;
	logic              out_valid_q;
	out_item_t         out_data_q;

	logic              retire, slot_free, is_full, take, decide, admit;
	logic [CW-1:0]     cap_ext, eff_cap;
	logic [TIME_W-1:0] start_c, fin_c;
	logic [TIME_W:0]   sum_c;

	assign head_next = (head_q == LAST_POS) ? '0 : head_q + AW'(1);
	assign tail_next = (tail_q == LAST_POS) ? '0 : tail_q + AW'(1);

	assign cap_ext = CW'(capacity);
	assign eff_cap = (cap_ext == '0) ? CW'(1) : ((cap_ext > DEPTH_C) ? DEPTH_C : cap_ext);

	assign retire    = (occ_q != '0) && (rd_q <= arr_q);
	assign slot_free = !out_valid_q || !out_stall;
	assign is_full   = CW'(occ_q) >= eff_cap;

	assign start_c = ((occ_q != '0) && (last_fin_q > arr_q)) ? last_fin_q : arr_q;
	assign sum_c   = {1'b0, start_c} + (TIME_W + 1)'(proc_q);
	assign fin_c   = sum_c[TIME_W] ? '1 : sum_c[TIME_W-1:0];

	always_comb begin
		state_d = state_q;
		take    = 1'b0;
		decide  = 1'b0;
		rd_addr = head_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					take    = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				// Each retired entry steps the read address so the next head is
				// ready in the following cycle.
				if (retire) begin
					rd_addr = head_next;
				end else if (slot_free) begin
					decide  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign admit   = decide && !is_full;
	assign req_pop = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CHECK && retire) begin
				head_q <= head_next;
				occ_q  <= occ_q - OW'(1);
			end else if (admit) begin
				tail_q <= tail_next;
				occ_q  <= occ_q + OW'(1);
			end
			if (decide)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= fifo_mem[rd_addr];
		if (admit) fifo_mem[tail_q] <= fin_c;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			arr_q  <= req_data.arrive_ts;
			proc_q <= req_data.service_len;
		end
		if (admit) last_fin_q <= fin_c;
		if (decide) begin
			out_data_q.dropped  <= is_full;
			out_data_q.start_ts <= is_full ? '0 : start_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ rtl/tail_drop_packet_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// tail_drop_packet_buffer_unit
// Single-server packet buffer with tail drop and finish-time bookkeeping.
// ----------------------------------------------------------------------------
// Each request carries a packet's arrival and processing time; each yields
// one result telling whether the packet was dropped and, if not, when its
// processing starts. A two-entry request queue takes requests while the
// engine works, and the result register holds a finished result while the
// next request is accepted. The engine takes each request through S_IDLE,
// S_READ and S_CHECK and stays in S_CHECK while it retires finished packets,
// because the finish-time memory is read at one address per cycle with
// registered data; a result still waiting in the result register holds the
// decision until it is taken. Reset leaves the buffer empty and the capacity
// at 16; capacity writes take effect for the next request decided.
module tail_drop_packet_buffer_unit import tdpb_pkg::*; #(
	parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	logic [CAP_W-1:0] capacity_q;
	logic             req_valid;
	logic             req_pop;
	in_item_t         req_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	tdpb_req_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.req_valid (req_valid),
		.req_data  (req_data),
		.req_pop   (req_pop)
	);

	tdpb_engine #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity_q),
		.req_valid (req_valid),
		.req_data  (req_data),
		.req_pop   (req_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ rtl/tdpb_checker.sv @@
// ----------------------------------------------------------------------------
// tdpb_checker
// Port-level checks of the packet buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "tail_drop_packet_buffer_unit_assert.svh"

module tdpb_checker import tdpb_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// A dropped packet never reports a start time.
	`TDPB_ASSERT_NOW(a_drop_zero, out_valid && out_data.dropped, out_data.start_ts == '0)

	// The request side only stalls once requests have piled up.
	`TDPB_ASSERT_NOW(a_stall_cause, in_stall, $past(in_valid && !in_stall) || $past(in_stall))

	// A waiting result stays and keeps its value.
	`TDPB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind tail_drop_packet_buffer_unit tdpb_checker u_tdpb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
